### hdl/stbs_pkg.sv
// shared constants and codes for the sorted table binary search block
package stbs_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int COUNT_W         = 9;
    localparam int SLOT_W          = 8;
    localparam int VALUE_W         = 32;
    localparam int POS_W           = 8;
    localparam int S_TDATA_W       = 40;
    localparam int M_TDATA_W       = 16;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

endpackage

### hdl/sorted_table_binary_search.sv
// sorted table of signed values with write and binary search beats
// latency: a write beat is stored at its accept edge and gives no result; a search result
// is registered after its last probe, up to floor(log2(count))+1 probes (9 at 256)
// throughput: a write beat every cycle while idle; a search holds s_tready low while it probes
// through the one read port of the table; an empty count skips the probes for the finish state
// a search ending while m_tvalid waits parks its result and holds s_tready low until m_tready
// reset: synchronous active low, clears element_count and control state, not the table
module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [COUNT_W-1:0]   cfg_wdata,   // element_count
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,     // slot[7:0], value[39:8]
    input  logic                 s_tuser,     // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata      // found[0], position[8:1], zero pad
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [VALUE_W-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]    low_reg, low_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;      // exclusive upper bound
    logic [CNT_W-1:0]    mid_reg, mid_next;
    logic                res_found_reg, res_found_next;
    logic [POS_W-1:0]    res_pos_reg, res_pos_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_found_reg, m_found_next;
    logic [POS_W-1:0]    m_pos_reg, m_pos_next;

    logic [VALUE_W-1:0]  mem [TABLE_DEPTH];
    logic [VALUE_W-1:0]  rd_data_reg;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;

    logic                op;
    logic [SLOT_W-1:0]   in_slot;
    logic [VALUE_W-1:0]  in_value;
    logic                s_accept;
    logic                out_free;
    logic [CNT_W-1:0]    n_sat;
    logic [CNT_W:0]      first_sum;
    logic [CNT_W:0]      probe_sum;
    logic                hit;
    logic                less;
    logic [CNT_W-1:0]    low_try;
    logic [CNT_W-1:0]    hi_try;

    assign op       = s_tuser;
    assign in_slot  = s_tdata[SLOT_W-1:0];
    assign in_value = s_tdata[SLOT_W +: VALUE_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - POS_W - 1){1'b0}}, m_pos_reg, m_found_reg};

    // count above depth saturates
    always_comb begin
        if (32'(count_reg) > 32'(TABLE_DEPTH)) begin
            n_sat = CNT_W'(TABLE_DEPTH);
        end else begin
            n_sat = CNT_W'(count_reg);
        end
    end

    assign wr_en = s_accept && (op == OP_WRITE) && (32'(in_slot) < 32'(TABLE_DEPTH));

    assign hit     = (rd_data_reg == key_reg);
    assign less    = ($signed(rd_data_reg) < $signed(key_reg));
    assign low_try = less ? (mid_reg + CNT_W'(1)) : low_reg;
    assign hi_try  = less ? hi_reg : mid_reg;

    // floor((low + high) / 2) with high = bound - 1
    assign first_sum = {1'b0, n_sat} - (CNT_W + 1)'(1);
    assign probe_sum = {1'b0, low_try} + {1'b0, hi_try} - (CNT_W + 1)'(1);

    always_comb begin
        state_next     = state_reg;
        key_next       = key_reg;
        low_next       = low_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_found_next   = m_found_reg;
        m_pos_next     = m_pos_reg;
        rd_en          = 1'b0;
        rd_addr        = mid_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && op == OP_SEARCH) begin
                    key_next = in_value;
                    if (n_sat == '0) begin
                        res_found_next = 1'b0;
                        res_pos_next   = '0;
                        state_next     = ST_FINISH;
                    end else begin
                        low_next   = '0;
                        hi_next    = n_sat;
                        mid_next   = first_sum[CNT_W:1];
                        rd_en      = 1'b1;
                        rd_addr    = first_sum[ADDR_W:1];
                        state_next = ST_COMPARE;
                    end
                end
            end
            ST_COMPARE: begin
                if (hit || low_try >= hi_try) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_found_next = hit;
                        m_pos_next   = hit ? POS_W'(mid_reg) : '0;
                        state_next   = ST_IDLE;
                    end else begin
                        res_found_next = hit;
                        res_pos_next   = hit ? POS_W'(mid_reg) : '0;
                        state_next     = ST_FINISH;
                    end
                end else begin
                    low_next = low_try;
                    hi_next  = hi_try;
                    mid_next = probe_sum[CNT_W:1];
                    rd_en    = 1'b1;
                    rd_addr  = probe_sum[ADDR_W:1];
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_pos_next   = res_pos_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
        end
        key_reg       <= key_next;
        low_reg       <= low_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        m_found_reg   <= m_found_next;
        m_pos_reg     <= m_pos_next;
    end

    // writes only land in idle, so a probe read never meets a write to the same entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[ADDR_W'(in_slot)] <= in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_notfound_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[POS_W:1] == '0)
        else $error("not-found result carries a nonzero position");

    a_range_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COMPARE |-> low_reg < hi_reg)
        else $error("probe issued on an empty range");

    a_mid_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COMPARE |-> (mid_reg >= low_reg) && (mid_reg < hi_reg))
        else $error("probe index outside the search range");

    a_search_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && op == OP_SEARCH && n_sat != '0 |=> state_reg == ST_COMPARE)
        else $error("search beat did not start probing");

    a_no_write_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg == ST_IDLE && !rd_en)
        else $error("table write overlaps a probe read");

endmodule

### tb/tb_sorted_table_binary_search.sv
`timescale 1ns / 100ps
// self-checking testbench for the sorted table binary search block
module tb_sorted_table_binary_search;
    import stbs_pkg::*;

    localparam int ITEM_TARGET   = 1950;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1200000;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } answer_t;

    // mirror of the table and count, queues the answer each search should give
    class table_mirror;
        logic [VALUE_W-1:0] entries [TABLE_DEPTH_DEF];
        bit                 written [TABLE_DEPTH_DEF];
        int unsigned        active_count;
        answer_t            pending_answers [$];
        int                 errors;

        function int written_prefix();
            int p;
            p = 0;
            while (p < TABLE_DEPTH_DEF && written[p]) p++;
            return p;
        endfunction

        function void take_input(logic op, logic [SLOT_W-1:0] slot, logic [VALUE_W-1:0] val);
            answer_t ans;
            int      lo, hi, mid, n;
            bit      hit;
            if (op == OP_WRITE) begin
                entries[slot] = val;
                written[slot] = 1'b1;
                return;
            end
            ans = '0;
            hit = 1'b0;
            n   = (active_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : active_count;
            lo  = 0;
            hi  = n - 1;
            while (!hit && lo <= hi) begin
                mid = (lo + hi) / 2;
                if (entries[mid] == val) begin
                    hit          = 1'b1;
                    ans.found    = 1'b1;
                    ans.position = mid[POS_W-1:0];
                end else if ($signed(entries[mid]) < $signed(val)) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
            pending_answers.push_back(ans);
        endfunction

        function void check_answer(logic [M_TDATA_W-1:0] beat);
            answer_t got, want;
            got.found    = beat[0];
            got.position = beat[POS_W:1];
            if (pending_answers.size() == 0) begin
                $display("%0t: result beat with nothing pending, found=%0b position=%0d",
                         $time, got.found, got.position);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found mismatch, expected %0b actual %0b",
                         $time, want.found, got.found);
                errors++;
            end
            if (got.position !== want.position) begin
                $display("%0t: position mismatch, expected %0d actual %0d",
                         $time, want.position, got.position);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [COUNT_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // slot[7:0], value[39:8]
    logic                 s_tuser   = 1'b0; // opcode
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // found[0], position[8:1], zero pad

    table_mirror mirror;
    int          items_sent   = 0;
    int          cycles       = 0;
    bit          steady       = 1'b0;
    bit          hold_off_req = 1'b0;

    sorted_table_binary_search u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic send_beat(input logic op, input logic [SLOT_W-1:0] slot,
                             input logic [VALUE_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        mirror.take_input(op, slot, val);
        items_sent++;
    endtask

    // drop valid, let every pending answer come back, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (mirror.pending_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(input int unsigned c);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= c[COUNT_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        mirror.active_count = c[COUNT_W-1:0];
    endtask

    // ascending run with duplicates, small and wide steps, clamped at the top
    task automatic fill_sorted(input int n);
        logic [VALUE_W-1:0] vals [TABLE_DEPTH_DEF];
        longint             lvl, step;
        int unsigned        span;
        int                 i, s;
        bit                 downward;
        span = 32'hFFFF_FFFF / (n + 1);
        case ($urandom_range(2))
            0: lvl = -64'sd2147483648;
            1: lvl = $signed($urandom()) / 2;
            default: lvl = $signed($urandom());
        endcase
        for (i = 0; i < n; i++) begin
            vals[i] = lvl[VALUE_W-1:0];
            case ($urandom_range(9))
                0, 1: step = 0;
                2, 3, 4, 5: step = $urandom_range(4, 1);
                default: step = $urandom_range(span);
            endcase
            lvl += step;
            if (lvl > 64'sd2147483647) lvl = 64'sd2147483647;
        end
        downward = ($urandom_range(3) == 0);
        for (i = 0; i < n; i++) begin
            s = downward ? n - 1 - i : i;
            send_beat(OP_WRITE, s[SLOT_W-1:0], vals[s]);
        end
    endtask

    task automatic search_round(input int k);
        int                 j, lim, r;
        logic [VALUE_W-1:0] key;
        logic [SLOT_W-1:0]  junk;
        lim = (mirror.active_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : mirror.active_count;
        if (lim == 0) lim = mirror.written_prefix();
        for (j = 0; j < k; j++) begin
            r    = $urandom_range(99);
            key  = $urandom();
            junk = SLOT_W'($urandom_range(255));
            if (lim > 0 && r < 60) key = mirror.entries[$urandom_range(lim - 1)];
            else if (lim > 0 && r < 70) key = mirror.entries[$urandom_range(lim - 1)] + 1;
            else if (lim > 0 && r < 80) key = mirror.entries[$urandom_range(lim - 1)] - 1;
            else if (r < 84) key = 32'h8000_0000;
            else if (r < 88) key = 32'h7FFF_FFFF;
            // a stray write in the middle of searches may break the ordering
            if (r >= 96) send_beat(OP_WRITE, junk, key);
            else send_beat(OP_SEARCH, junk, key);
        end
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) mirror.check_answer(m_tdata);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0 && !steady && $urandom_range(99) < 30) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int                phase, n, r, cnt, pre;
        bit                squeeze;
        logic [SLOT_W-1:0] s8;
        mirror = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table right after reset
        send_beat(OP_SEARCH, 8'hFF, 32'h0000_0000);
        send_beat(OP_SEARCH, 8'h00, 32'hFFFF_FFFF);
        send_beat(OP_WRITE, 8'd0, 32'h8000_0000);
        send_beat(OP_WRITE, 8'd1, 32'hFFFF_FFFB);
        send_beat(OP_WRITE, 8'd2, 32'h0000_0000);
        send_beat(OP_WRITE, 8'd3, 32'h0000_0007);
        send_beat(OP_WRITE, 8'd4, 32'h7FFF_FFFF);
        send_beat(OP_WRITE, 8'd255, 32'hA5A5_5A5A);
        write_count(5);
        send_beat(OP_SEARCH, 8'h00, 32'h8000_0000);
        send_beat(OP_SEARCH, 8'hFF, 32'h7FFF_FFFF);
        send_beat(OP_SEARCH, 8'h55, 32'h0000_0000);
        send_beat(OP_SEARCH, 8'hAA, 32'h0000_0007);
        send_beat(OP_SEARCH, 8'h01, 32'hFFFF_FFFB);
        send_beat(OP_SEARCH, 8'h02, 32'h0000_0003);
        send_beat(OP_SEARCH, 8'h03, 32'h8000_0001);
        send_beat(OP_SEARCH, 8'h04, 32'h7FFF_FFFE);
        write_count(1);
        send_beat(OP_SEARCH, 8'h00, 32'h8000_0000);
        send_beat(OP_SEARCH, 8'h00, 32'h0000_0000);
        // out-of-order entry, the probe path decides
        send_beat(OP_WRITE, 8'd2, 32'h0000_0064);
        write_count(5);
        send_beat(OP_SEARCH, 8'h00, 32'h0000_0064);
        send_beat(OP_SEARCH, 8'h00, 32'h0000_0007);

        // whole table, then counts past the depth
        fill_sorted(TABLE_DEPTH_DEF);
        write_count(TABLE_DEPTH_DEF);
        search_round(24);
        write_count(511);
        search_round(10);
        write_count(257);
        search_round(6);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            steady = ($urandom_range(99) < 15);
            r = $urandom_range(99);
            if (r < 70) n = $urandom_range(16, 1);
            else if (r < 90) n = $urandom_range(64, 17);
            else n = $urandom_range(TABLE_DEPTH_DEF, 65);
            fill_sorted(n);
            if ($urandom_range(9) == 0) begin
                s8 = SLOT_W'($urandom_range(n - 1));
                send_beat(OP_WRITE, s8, $urandom());
            end
            pre = mirror.written_prefix();
            r   = $urandom_range(99);
            if (r < 70) cnt = n;
            else if (r < 82) cnt = $urandom_range(pre);
            else if (r < 88) cnt = 0;
            else if (pre == TABLE_DEPTH_DEF && r < 94) cnt = $urandom_range(511, 257);
            else cnt = pre;
            write_count(cnt);
            // stall the result side while searches keep coming
            squeeze = (phase == 2) || ($urandom_range(99) < 4);
            if (squeeze) begin
                steady       = 1'b1;
                hold_off_req = 1'b1;
            end
            search_round(squeeze ? 40 : $urandom_range(40, 10));
            phase++;
        end
        steady = 1'b0;
        wait_drained();
        if (mirror.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
